/* rtl/pearson_correlation_split_means_defines.svh */
// Assertion macros for the Pearson correlation block.
// Included by the top level, which checks its own logic; depends on nothing.
`ifndef PEARSON_CORRELATION_SPLIT_MEANS_DEFINES_SVH
`define PEARSON_CORRELATION_SPLIT_MEANS_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PCSM_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("pcsm: same-cycle check failed");
`define PCSM_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("pcsm: next-cycle check failed");
`else
`define PCSM_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define PCSM_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

/* rtl/pcsm_pkg.sv */
// Shared widths, constants and register addresses of the Pearson correlation block.
// Used by the channel interfaces and the top level; depends on nothing.
package pcsm_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int SAMPLE_W      = 17;
    localparam int CORR_W        = 16;
    localparam int MAX_ITEMS_DEF = 1024;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 2;

    localparam logic [SAMPLE_W-1:0]   SAMPLE_ONE     = SAMPLE_W'(1) << FRAC_BITS;
    localparam logic [SAMPLE_W-1:0]   THRESH_RESET   = SAMPLE_W'(29491);
    localparam logic [APB_ADDR_W-1:0] ADDR_HIGH_THRESHOLD = APB_ADDR_W'(0);

endpackage

/* rtl/pcsm_sample_if.sv */
// Input channel carrying one (x, y) pair and its last-item flag.
// Depends on pcsm_pkg for the sample width.
interface pcsm_sample_if;
    logic                                valid;
    logic                                ready;
    logic [pcsm_pkg::SAMPLE_W-1:0]       x_value;
    logic [pcsm_pkg::SAMPLE_W-1:0]       y_value;
    logic                                last_item;

    modport source (output valid, x_value, y_value, last_item, input ready);
    modport sink   (input valid, x_value, y_value, last_item, output ready);
endinterface

/* rtl/pcsm_result_if.sv */
// Output channel carrying the correlation, split means and status flags.
// Depends on pcsm_pkg for the field widths.
interface pcsm_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [pcsm_pkg::CORR_W-1:0]  correlation;
    logic [pcsm_pkg::SAMPLE_W-1:0]       mean_high;
    logic [pcsm_pkg::SAMPLE_W-1:0]       mean_low;
    logic                                degenerate;
    logic                                overflowed;

    modport source (output valid, correlation, mean_high, mean_low, degenerate, overflowed,
                    input ready);
    modport sink   (input valid, correlation, mean_high, mean_low, degenerate, overflowed,
                    output ready);
endinterface

/* rtl/pearson_correlation_split_means.sv */
// Pearson correlation with split means: top level and its sequencer.
// Depends on pcsm_pkg, pcsm_sample_if, pcsm_result_if and the defines header.
//
// Usage: pairs (x, y) in unsigned Q1.16 arrive on the sample channel, one transaction
// each; values above 1.0 are clamped. A pair is accumulated in the cycle it is taken,
// so a set streams in at one pair per cycle. The pair flagged last closes the set:
// the block then drops ready and runs a shift-add multiplier, a bit-per-cycle
// root search and a restoring divider, all sequenced one after another.
// The closing computation takes eight products, each shifting through at most DW bits
// of multiplier (DW = 54 with 1024 items; a product ends early once its multiplier bits run out),
// a root search over 16 bits and two divisions of SW = 27 steps each. A degenerate set
// stops after four products and skips the rest. The result lands in an output register
// and the block is ready again; a stalled receiver only delays the next set's close.
// Pairs beyond MAX_ITEMS are dropped and flagged in the result. Reset clears all
// sums and sets high_threshold to about 0.45. The APB port writes the threshold.
`include "pearson_correlation_split_means_defines.svh"

module pearson_correlation_split_means #(
    parameter int MAX_ITEMS = pcsm_pkg::MAX_ITEMS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    pcsm_sample_if.sink                        sample,
    pcsm_result_if.source                      result,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pcsm_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [pcsm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pcsm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    localparam int XW  = pcsm_pkg::SAMPLE_W;
    localparam int QW  = pcsm_pkg::CORR_W;
    localparam int CW  = $clog2(MAX_ITEMS + 1);
    localparam int SW  = CW + pcsm_pkg::FRAC_BITS;
    localparam int SQW = CW + 2 * pcsm_pkg::FRAC_BITS;
    localparam int DW  = CW + SQW;
    localparam int PW  = 2 * DW;
    localparam int LW  = PW + 2 * QW;
    localparam int RS  = 2 * (QW - 1);
    localparam int QCW = $clog2(QW);
    localparam int DCW = $clog2(SW + 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MLOAD = 6'b000010,
        ST_MRUN  = 6'b000100,
        ST_SQRT  = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    typedef enum logic [2:0] {
        OP_NSXX = 3'd0,
        OP_SXSX = 3'd1,
        OP_NSYY = 3'd2,
        OP_SYSY = 3'd3,
        OP_NSXY = 3'd4,
        OP_SXSY = 3'd5,
        OP_DXDY = 3'd6,
        OP_CC   = 3'd7
    } op_t;

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [XW-1:0]     thresh_reg, thresh_next;
    logic [SW-1:0]     sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic [SW-1:0]     sum_yh_reg, sum_yh_next;
    logic [SQW-1:0]    sum_xx_reg, sum_xx_next, sum_yy_reg, sum_yy_next;
    logic [SQW-1:0]    sum_xy_reg, sum_xy_next;
    logic [CW-1:0]     cnt_reg, cnt_next, hcnt_reg, hcnt_next;
    logic              drop_reg, drop_next;
    logic [PW-1:0]     mul_a_reg, mul_a_next, acc_reg, acc_next;
    logic [DW-1:0]     mul_b_reg, mul_b_next;
    logic [PW-1:0]     tmp_reg, tmp_next, p_reg, p_next, t_reg, t_next;
    logic [DW-1:0]     dx_reg, dx_next, dy_reg, dy_next, c_reg, c_next;
    logic              neg_reg, neg_next, degen_reg, degen_next;
    logic [LW-1:0]     qqp_reg, qqp_next, rr_reg, rr_next, ps_reg, ps_next;
    logic [QW-1:0]     q_reg, q_next;
    logic [QCW-1:0]    sq_cnt_reg, sq_cnt_next;
    logic [CW:0]       rem_reg, rem_next;
    logic [SW-1:0]     quo_reg, quo_next;
    logic [CW-1:0]     dvs_reg, dvs_next;
    logic [DCW-1:0]    div_cnt_reg, div_cnt_next;
    logic              div_sel_reg, div_sel_next;
    logic [QW-1:0]     corr_reg, corr_next;
    logic [XW-1:0]     mh_reg, mh_next, ml_reg, ml_next;
    logic              res_valid_reg, res_valid_next;
    logic [QW-1:0]     o_corr_reg, o_corr_next;
    logic [XW-1:0]     o_mh_reg, o_mh_next, o_ml_reg, o_ml_next;
    logic              o_degen_reg, o_degen_next, o_ovf_reg, o_ovf_next;

    logic              in_fire;
    logic [XW-1:0]     x_c, y_c;
    logic [DW-1:0]     opa, opb;
    logic [PW-1:0]     spread;
    logic              spread_pos;
    logic [LW-1:0]     lhs, tgt;
    logic              take;
    logic [CW:0]       rem_sh;
    logic              qbit;
    logic [SW-1:0]     quo_step;
    logic [CW:0]       rem_step;
    logic [QW-1:0]     q_fin;
    logic [QW-1:0]     corr_val;

    assign pready       = 1'b1;
    assign prdata       = (paddr == pcsm_pkg::ADDR_HIGH_THRESHOLD)
                        ? pcsm_pkg::APB_DATA_W'(thresh_reg) : '0;
    assign sample.ready = (state_reg == ST_IDLE);
    assign in_fire      = sample.valid && sample.ready;

    assign result.valid       = res_valid_reg;
    assign result.correlation = o_corr_reg;
    assign result.mean_high   = o_mh_reg;
    assign result.mean_low    = o_ml_reg;
    assign result.degenerate  = o_degen_reg;
    assign result.overflowed  = o_ovf_reg;

    assign x_c = (sample.x_value > pcsm_pkg::SAMPLE_ONE) ? pcsm_pkg::SAMPLE_ONE : sample.x_value;
    assign y_c = (sample.y_value > pcsm_pkg::SAMPLE_ONE) ? pcsm_pkg::SAMPLE_ONE : sample.y_value;

    always_comb
    begin
        unique case (op_reg)
            OP_NSXX:
            begin
                opa = DW'(cnt_reg);
                opb = DW'(sum_xx_reg);
            end
            OP_SXSX:
            begin
                opa = DW'(sum_x_reg);
                opb = DW'(sum_x_reg);
            end
            OP_NSYY:
            begin
                opa = DW'(cnt_reg);
                opb = DW'(sum_yy_reg);
            end
            OP_SYSY:
            begin
                opa = DW'(sum_y_reg);
                opb = DW'(sum_y_reg);
            end
            OP_NSXY:
            begin
                opa = DW'(cnt_reg);
                opb = DW'(sum_xy_reg);
            end
            OP_SXSY:
            begin
                opa = DW'(sum_x_reg);
                opb = DW'(sum_y_reg);
            end
            OP_DXDY:
            begin
                opa = dx_reg;
                opb = dy_reg;
            end
            OP_CC:
            begin
                opa = c_reg;
                opb = c_reg;
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    assign spread_pos = tmp_reg > acc_reg;
    assign spread     = spread_pos ? (tmp_reg - acc_reg) : (acc_reg - tmp_reg);

    assign tgt  = LW'(t_reg) << RS;
    assign lhs  = qqp_reg + rr_reg + ps_reg;
    assign take = (lhs <= tgt);
    assign q_fin = {q_reg[QW-2:0], take};

    always_comb
    begin
        if (neg_reg)
        begin
            corr_val = (q_fin > (QW'(1) << (QW - 1))) ? (QW'(1) << (QW - 1)) : (QW'(0) - q_fin);
        end
        else
        begin
            corr_val = (q_fin > ((QW'(1) << (QW - 1)) - QW'(1)))
                     ? ((QW'(1) << (QW - 1)) - QW'(1)) : q_fin;
        end
    end

    assign rem_sh   = {rem_reg[CW-1:0], quo_reg[SW-1]};
    assign qbit     = (rem_sh >= (CW + 1)'(dvs_reg));
    assign rem_step = qbit ? (rem_sh - (CW + 1)'(dvs_reg)) : rem_sh;
    assign quo_step = {quo_reg[SW-2:0], qbit};

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        thresh_next    = thresh_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        sum_yh_next    = sum_yh_reg;
        sum_xx_next    = sum_xx_reg;
        sum_yy_next    = sum_yy_reg;
        sum_xy_next    = sum_xy_reg;
        cnt_next       = cnt_reg;
        hcnt_next      = hcnt_reg;
        drop_next      = drop_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        acc_next       = acc_reg;
        tmp_next       = tmp_reg;
        p_next         = p_reg;
        t_next         = t_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        c_next         = c_reg;
        neg_next       = neg_reg;
        degen_next     = degen_reg;
        qqp_next       = qqp_reg;
        rr_next        = rr_reg;
        ps_next        = ps_reg;
        q_next         = q_reg;
        sq_cnt_next    = sq_cnt_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dvs_next       = dvs_reg;
        div_cnt_next   = div_cnt_reg;
        div_sel_next   = div_sel_reg;
        corr_next      = corr_reg;
        mh_next        = mh_reg;
        ml_next        = ml_reg;
        res_valid_next = res_valid_reg;
        o_corr_next    = o_corr_reg;
        o_mh_next      = o_mh_reg;
        o_ml_next      = o_ml_reg;
        o_degen_next   = o_degen_reg;
        o_ovf_next     = o_ovf_reg;

        if (psel && penable && pwrite)
        begin
            thresh_next = pwdata[XW-1:0];
        end

        if (res_valid_reg && result.ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (cnt_reg >= CW'(MAX_ITEMS))
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        sum_x_next  = sum_x_reg + SW'(x_c);
                        sum_y_next  = sum_y_reg + SW'(y_c);
                        sum_xx_next = sum_xx_reg + SQW'(x_c) * SQW'(x_c);
                        sum_yy_next = sum_yy_reg + SQW'(y_c) * SQW'(y_c);
                        sum_xy_next = sum_xy_reg + SQW'(x_c) * SQW'(y_c);
                        cnt_next    = cnt_reg + CW'(1);
                        if (x_c >= thresh_reg)
                        begin
                            sum_yh_next = sum_yh_reg + SW'(y_c);
                            hcnt_next   = hcnt_reg + CW'(1);
                        end
                    end
                    if (sample.last_item)
                    begin
                        degen_next = 1'b0;
                        op_next    = OP_NSXX;
                        state_next = ST_MLOAD;
                    end
                end
            end
            ST_MLOAD:
            begin
                mul_a_next = PW'(opa);
                mul_b_next = opb;
                acc_next   = '0;
                state_next = ST_MRUN;
            end
            ST_MRUN:
            begin
                if (mul_b_reg != '0)
                begin
                    if (mul_b_reg[0])
                    begin
                        acc_next = acc_reg + mul_a_reg;
                    end
                    mul_a_next = mul_a_reg << 1;
                    mul_b_next = mul_b_reg >> 1;
                end
                else
                begin
                    op_next    = op_t'(op_reg + 3'd1);
                    state_next = ST_MLOAD;
                    unique case (op_reg)
                        OP_NSXX, OP_NSYY, OP_NSXY:
                        begin
                            tmp_next = acc_reg;
                        end
                        OP_SXSX:
                        begin
                            dx_next = spread_pos ? spread[DW-1:0] : '0;
                        end
                        OP_SYSY:
                        begin
                            dy_next = spread_pos ? spread[DW-1:0] : '0;
                            if (dx_reg == '0 || !spread_pos)
                            begin
                                degen_next = 1'b1;
                                corr_next  = '0;
                                mh_next    = '0;
                                ml_next    = '0;
                                state_next = ST_FIN;
                            end
                        end
                        OP_SXSY:
                        begin
                            neg_next = (tmp_reg < acc_reg);
                            c_next   = spread[DW-1:0];
                        end
                        OP_DXDY:
                        begin
                            p_next = acc_reg;
                        end
                        OP_CC:
                        begin
                            t_next      = acc_reg;
                            qqp_next    = '0;
                            rr_next     = '0;
                            ps_next     = LW'(p_reg) << RS;
                            q_next      = '0;
                            sq_cnt_next = QCW'(QW - 1);
                            state_next  = ST_SQRT;
                        end
                        default:
                        begin
                            state_next = ST_MLOAD;
                        end
                    endcase
                end
            end
            ST_SQRT:
            begin
                // Each step tries the next bit of |r| from the top down.
                if (take)
                begin
                    qqp_next = lhs;
                end
                rr_next = (rr_reg >> 1) + (take ? ps_reg : LW'(0));
                ps_next = ps_reg >> 2;
                q_next  = q_fin;
                if (sq_cnt_reg == '0)
                begin
                    corr_next    = corr_val;
                    rem_next     = '0;
                    quo_next     = sum_yh_reg;
                    dvs_next     = hcnt_reg;
                    div_cnt_next = DCW'(SW);
                    div_sel_next = 1'b0;
                    state_next   = ST_DIV;
                end
                else
                begin
                    sq_cnt_next = sq_cnt_reg - QCW'(1);
                end
            end
            ST_DIV:
            begin
                rem_next     = rem_step;
                quo_next     = quo_step;
                div_cnt_next = div_cnt_reg - DCW'(1);
                if (div_cnt_reg == DCW'(1))
                begin
                    if (!div_sel_reg)
                    begin
                        mh_next      = (dvs_reg == '0) ? '0 : quo_step[XW-1:0];
                        rem_next     = '0;
                        quo_next     = sum_y_reg - sum_yh_reg;
                        dvs_next     = cnt_reg - hcnt_reg;
                        div_cnt_next = DCW'(SW);
                        div_sel_next = 1'b1;
                    end
                    else
                    begin
                        ml_next    = (dvs_reg == '0) ? '0 : quo_step[XW-1:0];
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    res_valid_next = 1'b1;
                    o_corr_next    = corr_reg;
                    o_mh_next      = mh_reg;
                    o_ml_next      = ml_reg;
                    o_degen_next   = degen_reg;
                    o_ovf_next     = drop_reg;
                    sum_x_next     = '0;
                    sum_y_next     = '0;
                    sum_yh_next    = '0;
                    sum_xx_next    = '0;
                    sum_yy_next    = '0;
                    sum_xy_next    = '0;
                    cnt_next       = '0;
                    hcnt_next      = '0;
                    drop_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_NSXX;
            thresh_reg    <= pcsm_pkg::THRESH_RESET;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_yh_reg    <= '0;
            sum_xx_reg    <= '0;
            sum_yy_reg    <= '0;
            sum_xy_reg    <= '0;
            cnt_reg       <= '0;
            hcnt_reg      <= '0;
            drop_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            degen_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            thresh_reg    <= thresh_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            sum_yh_reg    <= sum_yh_next;
            sum_xx_reg    <= sum_xx_next;
            sum_yy_reg    <= sum_yy_next;
            sum_xy_reg    <= sum_xy_next;
            cnt_reg       <= cnt_next;
            hcnt_reg      <= hcnt_next;
            drop_reg      <= drop_next;
            res_valid_reg <= res_valid_next;
            degen_reg     <= degen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        acc_reg     <= acc_next;
        tmp_reg     <= tmp_next;
        p_reg       <= p_next;
        t_reg       <= t_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        c_reg       <= c_next;
        neg_reg     <= neg_next;
        qqp_reg     <= qqp_next;
        rr_reg      <= rr_next;
        ps_reg      <= ps_next;
        q_reg       <= q_next;
        sq_cnt_reg  <= sq_cnt_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        dvs_reg     <= dvs_next;
        div_cnt_reg <= div_cnt_next;
        div_sel_reg <= div_sel_next;
        corr_reg    <= corr_next;
        mh_reg      <= mh_next;
        ml_reg      <= ml_next;
        o_corr_reg  <= o_corr_next;
        o_mh_reg    <= o_mh_next;
        o_ml_reg    <= o_ml_next;
        o_degen_reg <= o_degen_next;
        o_ovf_reg   <= o_ovf_next;
    end

    `PCSM_ASSERT_IMP(a_count_cap, clk, rst_n, 1'b1, cnt_reg <= CW'(MAX_ITEMS))
    `PCSM_ASSERT_IMP(a_high_le_count, clk, rst_n, 1'b1, hcnt_reg <= cnt_reg)
    `PCSM_ASSERT_IMP(a_degen_zero, clk, rst_n, result.valid && result.degenerate,
        result.correlation == '0 && result.mean_high == '0 && result.mean_low == '0)
    `PCSM_ASSERT_NEXT(a_close_clears, clk, rst_n,
        (state_reg == ST_FIN) && (!res_valid_reg || result.ready),
        result.valid && cnt_reg == '0 && sample.ready)

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the Pearson correlation block with split means.
// Drives pairs with random gaps and stalls and checks every result against a predictor or a directed expectation.
// Depends on pcsm_pkg, pcsm_sample_if, pcsm_result_if and the block's RTL.
module tb_top;

    localparam int CORR_W     = pcsm_pkg::CORR_W;
    localparam int SAMPLE_W   = pcsm_pkg::SAMPLE_W;
    localparam int APB_ADDR_W = pcsm_pkg::APB_ADDR_W;
    localparam int APB_DATA_W = pcsm_pkg::APB_DATA_W;
    localparam logic [SAMPLE_W-1:0]   SAMPLE_ONE          = pcsm_pkg::SAMPLE_ONE;
    localparam logic [SAMPLE_W-1:0]   THRESH_RESET        = pcsm_pkg::THRESH_RESET;
    localparam logic [APB_ADDR_W-1:0] ADDR_HIGH_THRESHOLD = pcsm_pkg::ADDR_HIGH_THRESHOLD;

    typedef logic [255:0] wide_t;

    typedef struct packed {
        logic [CORR_W-1:0]   correlation;
        logic [SAMPLE_W-1:0] mean_high;
        logic [SAMPLE_W-1:0] mean_low;
        logic                degenerate;
        logic                overflowed;
    } corr_result_t;

    typedef struct {
        logic [SAMPLE_W-1:0] x;
        logic [SAMPLE_W-1:0] y;
        logic                last;
        logic                typed;
        corr_result_t        want;
    } pair_row_t;

    localparam int CAPACITY    = pcsm_pkg::MAX_ITEMS_DEF;
    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel, penable, pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata, prdata;
    logic pready;

    pcsm_sample_if smp();
    pcsm_result_if res();

    pearson_correlation_split_means DUT (
        .clk(clk), .rst_n(rst_n), .sample(smp), .result(res),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 clk = ~clk;

    // Predictor state
    logic [SAMPLE_W-1:0] threshold_q;
    logic [63:0] acc_x, acc_y, acc_xx, acc_yy, acc_xy, acc_y_high, acc_n, acc_high;
    logic        acc_dropped;

    corr_result_t pending_results[$];
    int errors = 0;
    int pairs_sent = 0;
    int sets_closed = 0;
    int dropped_sets = 0;
    int degenerate_sets = 0;
    int cycles = 0;
    bit quiet = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic wide_t spread(logic [63:0] n, logic [63:0] sq, logic [63:0] s);
        wide_t a, b;
        a = wide_t'(n) * wide_t'(sq);
        b = wide_t'(s) * wide_t'(s);
        return (a > b) ? a - b : '0;
    endfunction

    task automatic clear_sums();
        acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0; acc_xy = 0;
        acc_y_high = 0; acc_n = 0; acc_high = 0; acc_dropped = 0;
    endtask

    task automatic absorb_pair(input logic [SAMPLE_W-1:0] xi, input logic [SAMPLE_W-1:0] yi,
                               input logic lst, output logic produced,
                               output corr_result_t r);
        logic [63:0] x, y, q, cand, n_low;
        wide_t dx, dy, num_a, num_b, cmag, prod, target, lhs;
        logic negative;
        x = (xi > SAMPLE_ONE) ? 64'(SAMPLE_ONE) : 64'(xi);
        y = (yi > SAMPLE_ONE) ? 64'(SAMPLE_ONE) : 64'(yi);
        r = '0;
        produced = lst;
        if (acc_n >= CAPACITY)
            acc_dropped = 1;
        else
        begin
            acc_x += x; acc_y += y;
            acc_xx += x * x; acc_yy += y * y; acc_xy += x * y;
            if (x >= 64'(threshold_q))
            begin
                acc_y_high += y;
                acc_high++;
            end
            acc_n++;
        end
        if (!lst)
            return;
        dx = spread(acc_n, acc_xx, acc_x);
        dy = spread(acc_n, acc_yy, acc_y);
        r.degenerate = (acc_n == 0) || (dx == 0) || (dy == 0);
        if (!r.degenerate)
        begin
            num_a = wide_t'(acc_n) * wide_t'(acc_xy);
            num_b = wide_t'(acc_x) * wide_t'(acc_y);
            negative = num_a < num_b;
            cmag = negative ? num_b - num_a : num_a - num_b;
            prod = dx * dy;
            target = (cmag * cmag) << 30;
            q = 0;
            for (int b = 15; b >= 0; b--)
            begin
                cand = q | (64'd1 << b);
                lhs = wide_t'(cand * cand) * prod;
                if (lhs <= target)
                    q = cand;
            end
            if (negative)
            begin
                if (q > 32768)
                    q = 32768;
                r.correlation = 16'(65536 - q);
            end
            else
            begin
                if (q > 32767)
                    q = 32767;
                r.correlation = 16'(q);
            end
            if (acc_high != 0)
                r.mean_high = SAMPLE_W'(acc_y_high / acc_high);
            n_low = acc_n - acc_high;
            if (n_low != 0)
                r.mean_low = SAMPLE_W'((acc_y - acc_y_high) / n_low);
        end
        r.overflowed = acc_dropped;
        clear_sums();
    endtask

    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    task automatic push_pair(input pair_row_t row);
        logic produced;
        corr_result_t r;
        if (!quiet && $urandom_range(0, 2) == 0)
        begin
            smp.valid <= 1'b0;
            repeat (pick_gap()) @(posedge clk);
        end
        smp.valid     <= 1'b1;
        smp.x_value   <= row.x;
        smp.y_value   <= row.y;
        smp.last_item <= row.last;
        do
            @(posedge clk);
        while (!smp.ready);
        pairs_sent++;
        absorb_pair(row.x, row.y, row.last, produced, r);
        if (produced)
            pending_results.push_back(row.typed ? row.want : r);
    endtask

    task automatic send_pair(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y,
                             input logic lst);
        pair_row_t row;
        row.x = x; row.y = y; row.last = lst; row.typed = 0; row.want = '0;
        push_pair(row);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] a,
                              input logic [APB_DATA_W-1:0] d,
                              output logic [APB_DATA_W-1:0] rd);
        psel <= 1'b1; penable <= 1'b0; pwrite <= wr; paddr <= a; pwdata <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic set_threshold(input logic [SAMPLE_W-1:0] value);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b1, ADDR_HIGH_THRESHOLD, APB_DATA_W'(value), rd);
        threshold_q = value;
        apb_access(1'b0, ADDR_HIGH_THRESHOLD, '0, rd);
        if (rd[SAMPLE_W-1:0] !== value)
        begin
            $error("high_threshold readback: expected %0d actual %0d", value, rd);
            errors++;
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return SAMPLE_ONE;
            2: return SAMPLE_W'($urandom_range(65537, 131071));
            default: return SAMPLE_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] near(input int v);
        int t;
        t = v + $urandom_range(0, 2000) - 1000;
        if (t < 0)
            t = 0;
        if (t > 65536)
            t = 65536;
        return SAMPLE_W'(t);
    endfunction

    task automatic random_set(input int size);
        int mode;
        int xc;
        logic [SAMPLE_W-1:0] x, y;
        mode = $urandom_range(0, 2);
        quiet = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < size; i++)
        begin
            x = pick_value();
            xc = (x > SAMPLE_ONE) ? 65536 : int'(x);
            case (mode)
                0: y = pick_value();
                1: y = near(xc);
                default: y = near(65536 - xc);
            endcase
            send_pair(x, y, i == size - 1);
        end
    endtask

    task automatic wait_drained();
        wait (pending_results.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        corr_result_t w;
        if (rst_n && res.valid && res.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction with no expectation waiting");
                errors++;
            end
            else
            begin
                w = pending_results.pop_front();
                sets_closed++;
                if (w.overflowed)
                    dropped_sets++;
                if (w.degenerate)
                    degenerate_sets++;
                if (res.correlation !== w.correlation)
                begin
                    $error("correlation: expected %0d actual %0d",
                           $signed(w.correlation), res.correlation);
                    errors++;
                end
                if (res.mean_high !== w.mean_high)
                begin
                    $error("mean_high: expected %0d actual %0d", w.mean_high, res.mean_high);
                    errors++;
                end
                if (res.mean_low !== w.mean_low)
                begin
                    $error("mean_low: expected %0d actual %0d", w.mean_low, res.mean_low);
                    errors++;
                end
                if (res.degenerate !== w.degenerate)
                begin
                    $error("degenerate: expected %0d actual %0d", w.degenerate, res.degenerate);
                    errors++;
                end
                if (res.overflowed !== w.overflowed)
                begin
                    $error("overflowed: expected %0d actual %0d", w.overflowed, res.overflowed);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off while the sender keeps offering.
    initial
    begin
        bit long_done;
        long_done = 0;
        res.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!long_done && sets_closed >= 3)
            begin
                long_done = 1;
                res.ready <= 1'b0;
                repeat (1500) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                res.ready <= 1'b0;
                repeat (pick_gap()) @(posedge clk);
            end
            res.ready <= 1'b1;
        end
    end

    pair_row_t directed[] = '{
        '{17'd0,      17'd0,      1'b1, 1'b1, '{16'd0,      17'd0,     17'd0,     1'b1, 1'b0}},
        '{17'd0,      17'd0,      1'b0, 1'b0, '0},
        '{17'd65536,  17'd65536,  1'b1, 1'b1, '{16'd32767,  17'd65536, 17'd0,     1'b0, 1'b0}},
        '{17'd0,      17'd65536,  1'b0, 1'b0, '0},
        '{17'd65536,  17'd0,      1'b1, 1'b1, '{16'h8000,   17'd0,     17'd65536, 1'b0, 1'b0}},
        '{17'd131071, 17'd131071, 1'b0, 1'b0, '0},
        '{17'd0,      17'd0,      1'b1, 1'b1, '{16'd32767,  17'd65536, 17'd0,     1'b0, 1'b0}},
        '{17'd0,      17'd5,      1'b0, 1'b0, '0},
        '{17'd65536,  17'd5,      1'b1, 1'b1, '{16'd0,      17'd0,     17'd0,     1'b1, 1'b0}},
        '{17'd29491,  17'd100,    1'b0, 1'b0, '0},
        '{17'd29490,  17'd200,    1'b0, 1'b0, '0},
        '{17'd1000,   17'd300,    1'b1, 1'b0, '0},
        '{17'd12345,  17'd54321,  1'b0, 1'b0, '0},
        '{17'd65535,  17'd1,      1'b0, 1'b0, '0},
        '{17'd43690,  17'd43690,  1'b0, 1'b0, '0},
        '{17'd1,      17'd65535,  1'b1, 1'b0, '0}
    };

    initial
    begin
        logic [APB_DATA_W-1:0] rd;
        logic [SAMPLE_W-1:0] settings[$];
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        smp.valid <= 1'b0; smp.x_value <= '0; smp.y_value <= '0; smp.last_item <= 1'b0;
        threshold_q = THRESH_RESET;
        clear_sums();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_access(1'b0, ADDR_HIGH_THRESHOLD, '0, rd);
        if (rd[SAMPLE_W-1:0] !== THRESH_RESET)
        begin
            $error("high_threshold after reset: expected %0d actual %0d", THRESH_RESET, rd);
            errors++;
        end

        foreach (directed[i])
            push_pair(directed[i]);
        while (pairs_sent < 60)
            random_set($urandom_range(1, 8));
        smp.valid <= 1'b0;
        wait_drained();

        settings = '{17'd0, 17'd65536, 17'd131071, SAMPLE_W'($urandom_range(0, 65536)),
                     SAMPLE_W'($urandom_range(0, 65536))};
        foreach (settings[p])
        begin
            smp.valid <= 1'b0;
            wait_drained();
            set_threshold(settings[p]);
            if (p == settings.size() - 1)
            begin
                quiet = 0;
                for (int i = 0; i < CAPACITY + 2; i++)
                    send_pair(pick_value(), pick_value(), i == CAPACITY + 1);
            end
            repeat (8) random_set($urandom_range(1, 10));
        end
        smp.valid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (600) @(posedge clk);
        $display("Sent %0d pairs in %0d closed sets over %0d thresholds.",
                 pairs_sent, sets_closed, settings.size() + 1);
        $display("Sets with dropped pairs: %0d, degenerate sets: %0d.",
                 dropped_sets, degenerate_sets);
        if (errors == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl
rtl/pcsm_pkg.sv
rtl/pcsm_sample_if.sv
rtl/pcsm_result_if.sv
rtl/pearson_correlation_split_means.sv
dv/tb_top.sv
